// ----- design/rbst_pkg.sv -----
// Shared constants and types for the ray/box slab test pipeline.
package rbst_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_AXES    = 3;

    // Divider: magnitude stage, setup stage, one stage per quotient bit, sign stage.
    localparam int DIV_LAT = COORD_WIDTH + 3;

    localparam int IN_FIELDS = 4 * NUM_AXES;
    localparam int IN_BITS   = IN_FIELDS * COORD_WIDTH;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + 2 * COORD_WIDTH;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic dpos;
        logic dzero;
        logic in_slab;
    } axis_flags_t;

endpackage

// ----- design/rbst_div.sv -----
// Pipelined fixed-point slab divider: (corner - origin) * 2^FRAC_BITS / dir, saturated.
module rbst_div
    import rbst_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t corner,
    input  coord_t origin,
    input  coord_t dir,
    output coord_t quot
);

    localparam int W  = COORD_WIDTH;
    localparam int XW = 2 * W + FRAC_BITS + 1;

    // magnitude stage
    logic signed [W:0] c_ext;
    logic signed [W:0] o_ext;
    logic signed [W:0] diff;
    logic [W:0]        nmag_next;
    logic [W-1:0]      dmag_next;
    logic              neg_next;

    logic [W:0]   nmag_reg;
    logic [W-1:0] dmag_reg;
    logic         neg_reg;

    always_comb
    begin
        c_ext     = {corner[W-1], corner};
        o_ext     = {origin[W-1], origin};
        diff      = c_ext - o_ext;
        nmag_next = diff[W] ? (W+1)'(-diff) : diff;
        dmag_next = dir[W-1] ? W'(-dir) : dir;
        neg_next  = diff[W] != dir[W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= nmag_next;
            dmag_reg <= dmag_next;
            neg_reg  <= neg_next;
        end
    end

    // setup stage: overflow check and first partial remainder
    logic [XW-1:0] num_wide;
    logic [XW-1:0] den_wide;

    logic [W-1:0] rem_reg  [W+1];
    logic [W-1:0] nlow_reg [W+1];
    logic [W-1:0] q_reg    [W+1];
    logic [W-1:0] dmag_p_reg [W+1];
    logic         neg_p_reg  [W+1];
    logic         ovf_p_reg  [W+1];

    always_comb
    begin
        num_wide = XW'(nmag_reg) << FRAC_BITS;
        den_wide = XW'(dmag_reg) << W;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]    <= W'(num_wide >> W);
            nlow_reg[0]   <= num_wide[W-1:0];
            q_reg[0]      <= '0;
            dmag_p_reg[0] <= dmag_reg;
            neg_p_reg[0]  <= neg_reg;
            ovf_p_reg[0]  <= num_wide >= den_wide;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < W; k++)
    begin : g_bit
        logic [W:0] trial;
        logic [W:0] diff_k;
        logic       ge;

        always_comb
        begin
            trial  = {rem_reg[k], nlow_reg[k][W-1]};
            diff_k = trial - {1'b0, dmag_p_reg[k]};
            ge     = trial >= {1'b0, dmag_p_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]    <= ge ? diff_k[W-1:0] : trial[W-1:0];
                nlow_reg[k+1]   <= {nlow_reg[k][W-2:0], 1'b0};
                q_reg[k+1]      <= {q_reg[k][W-2:0], ge};
                dmag_p_reg[k+1] <= dmag_p_reg[k];
                neg_p_reg[k+1]  <= neg_p_reg[k];
                ovf_p_reg[k+1]  <= ovf_p_reg[k];
            end
        end
    end

    // saturate and apply sign
    logic [W-1:0] lim;
    logic [W-1:0] qsat;
    coord_t       quot_next;
    coord_t       quot_reg;

    always_comb
    begin
        lim  = neg_p_reg[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        qsat = (ovf_p_reg[W] || q_reg[W] > lim) ? lim : q_reg[W];
        quot_next = neg_p_reg[W] ? coord_t'(-qsat) : coord_t'(qsat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// ----- design/ray_box_slab_test.sv -----
// Ray against axis-aligned box, slab method, fully pipelined.
// Path from input accept to output valid: divider stages, reduction register, output register.
// Throughput: one request per cycle unless the output stalls; six divider lanes, one quotient bit per stage.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; no result is pending afterward.
module ray_box_slab_test
    import rbst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // origin_x,y,z, direction_x,y,z, box_low_x,y,z, box_high_x,y,z (low bits first)
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit, entry_distance, exit_distance, zero pad (low bits first)
    output logic [OUT_W-1:0] m_tdata
);

    localparam int W = COORD_WIDTH;

    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    coord_t      org  [NUM_AXES];
    coord_t      dirv [NUM_AXES];
    coord_t      blo  [NUM_AXES];
    coord_t      bhi  [NUM_AXES];
    axis_flags_t flg_next [NUM_AXES];
    coord_t      q_lo [NUM_AXES];
    coord_t      q_hi [NUM_AXES];

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        assign org[a]  = s_tdata[a*W +: W];
        assign dirv[a] = s_tdata[(NUM_AXES+a)*W +: W];
        assign blo[a]  = s_tdata[(2*NUM_AXES+a)*W +: W];
        assign bhi[a]  = s_tdata[(3*NUM_AXES+a)*W +: W];

        always_comb
        begin
            flg_next[a].dpos    = !dirv[a][W-1] && (dirv[a] != '0);
            flg_next[a].dzero   = dirv[a] == '0;
            flg_next[a].in_slab = (blo[a] <= org[a]) && (org[a] <= bhi[a]);
        end

        rbst_div u_div_lo
        (
            .clk    (clk),
            .en     (en),
            .corner (blo[a]),
            .origin (org[a]),
            .dir    (dirv[a]),
            .quot   (q_lo[a])
        );

        rbst_div u_div_hi
        (
            .clk    (clk),
            .en     (en),
            .corner (bhi[a]),
            .origin (org[a]),
            .dir    (dirv[a]),
            .quot   (q_hi[a])
        );
    end

    // valid and axis flags travel alongside the dividers
    logic [DIV_LAT-1:0] vld_reg;
    axis_flags_t        flg_reg [DIV_LAT][NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg[0] <= flg_next;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                flg_reg[s] <= flg_reg[s-1];
            end
        end
    end

    // pick near/far per axis, reduce to entry and exit
    localparam coord_t MAXV = {1'b0, {(W-1){1'b1}}};
    localparam coord_t MINV = {1'b1, {(W-1){1'b0}}};

    coord_t near_v [NUM_AXES];
    coord_t far_v  [NUM_AXES];
    coord_t entry_next;
    coord_t exit_next;

    always_comb
    begin
        entry_next = MINV;
        exit_next  = MAXV;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (flg_reg[DIV_LAT-1][a].dzero)
            begin
                near_v[a] = flg_reg[DIV_LAT-1][a].in_slab ? MINV : MAXV;
                far_v[a]  = flg_reg[DIV_LAT-1][a].in_slab ? MAXV : MINV;
            end
            else if (flg_reg[DIV_LAT-1][a].dpos)
            begin
                near_v[a] = q_lo[a];
                far_v[a]  = q_hi[a];
            end
            else
            begin
                near_v[a] = q_hi[a];
                far_v[a]  = q_lo[a];
            end
            if (near_v[a] > entry_next)
            begin
                entry_next = near_v[a];
            end
            if (far_v[a] < exit_next)
            begin
                exit_next = far_v[a];
            end
        end
    end

    logic   red_vld_reg;
    coord_t entry_reg;
    coord_t exit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            red_vld_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
        end
    end

    // output register
    logic   hit_reg;
    coord_t out_entry_reg;
    coord_t out_exit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= red_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg       <= (entry_reg <= exit_reg) && !exit_reg[W-1];
            out_entry_reg <= entry_reg;
            out_exit_reg  <= exit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_exit_reg, out_entry_reg, hit_reg});

    a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && hit_reg |-> (out_entry_reg <= out_exit_reg) && !out_exit_reg[W-1])
        else $error("hit set with entry after exit or negative exit");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(red_vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !m_tready |-> !s_tready)
        else $error("request accepted while output stalled");

    a_miss_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_LAT-1] && flg_reg[DIV_LAT-1][0].dzero && !flg_reg[DIV_LAT-1][0].in_slab
        && en |=> !(entry_reg <= exit_reg && !exit_reg[W-1]))
        else $error("zero direction outside slab did not miss");

endmodule
